FILE: rtl/npp_pkg.sv
package npp_pkg;

  localparam int unsigned BITS_PER_READ = 8;
  localparam int unsigned BIT_CNT_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FAMICON_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd2;

  localparam logic [7:0] LATCH_TICKS_RST = 8'd12;
  localparam logic [7:0] HALF_BIT_TICKS_RST = 8'd6;

  localparam logic [7:0] AXIS_CENTER = 8'h80;
  localparam logic [7:0] AXIS_MAX = 8'hff;
  localparam logic [7:0] AXIS_MIN = 8'h00;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_FAMICOM,
    MODE_A_HELD,
    MODE_B_HELD
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LATCH,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [3:0] buttons;
    logic       mic_changed;
  } report_t;

endpackage

FILE: rtl/nes_pad_poller_hid_report_top.sv
// NES pad poller: each request is one time-base tick and produces exactly one
// result. A poll request while idle drives the latch high for latch_ticks,
// then reads 8 bits MSB first, each as half_bit_ticks of clock high followed
// by half_bit_ticks of clock low, sampling the inverted data line on the first
// low tick. On the last tick of a read a report (axes and four mapped buttons)
// is flagged if the byte changed or a microphone press is pending. Throughput
// is one request per cycle unless out_stall holds a valid result; a request passes
// the input register, then the sequencer state update, then the result register.
// Configuration writes take effect on the next processed request.
module nes_pad_poller_hid_report_top
  import npp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_poll,
  input  logic                  in_data_level,
  input  logic                  in_mic_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_latch_out,
  output logic                  out_clock_out,
  output logic                  out_busy_res,
  output logic                  out_report_valid,
  output logic [7:0]            out_axis_x,
  output logic [7:0]            out_axis_y,
  output logic [3:0]            out_buttons
);

  // configuration
  mode_t      mode_r;
  logic [7:0] latch_ticks_r;
  logic [7:0] half_bit_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_PLAIN;
      latch_ticks_r    <= LATCH_TICKS_RST;
      half_bit_ticks_r <= HALF_BIT_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FAMICON_MODE) mode_r <= mode_t'(cfg_wdata[1:0]);
      if (cfg_index == CFG_LATCH_TICKS) latch_ticks_r <= cfg_wdata;
      if (cfg_index == CFG_HALF_BIT_TICKS) half_bit_ticks_r <= cfg_wdata;
    end
  end

  // input register
  logic in_valid_r;
  logic start_r;
  logic data_r;
  logic mic_r;
  logic out_valid_r;
  logic advance;
  logic step;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      start_r <= in_start_poll;
      data_r  <= in_data_level;
      mic_r   <= in_mic_level;
    end
  end

  // sequencer state
  phase_t               phase_r, phase_nxt;
  logic [7:0]           tick_count_r, tick_count_nxt;
  logic [BIT_CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [7:0]           shift_byte_r, shift_byte_nxt;
  logic [7:0]           last_reported_r, last_reported_nxt;
  logic                 mic_pending_r, mic_pending_nxt;
  logic                 mic_changed_r, mic_changed_nxt;

  phase_t               ph_eff;
  logic [7:0]           tc_eff;
  logic [BIT_CNT_W-1:0] bc_eff;
  logic [7:0]           sb_eff;
  logic [7:0]           tc_inc;
  logic [7:0]           len;
  logic                 end_phase;
  logic [BIT_CNT_W:0]   bc_inc;
  logic                 last_bit;
  logic                 done;
  logic                 mic_p1;
  logic                 mic_c1;
  logic                 report;
  report_t              rpt;

  always_comb begin
    ph_eff = phase_r;
    tc_eff = tick_count_r;
    bc_eff = bit_count_r;
    sb_eff = shift_byte_r;
    if (phase_r == PH_IDLE && start_r) begin
      ph_eff = PH_LATCH;
      tc_eff = 8'd0;
      bc_eff = '0;
      sb_eff = 8'd0;
    end
  end

  assign len       = (ph_eff == PH_LATCH) ? latch_ticks_r : half_bit_ticks_r;
  assign tc_inc    = tc_eff + 8'd1;
  assign end_phase = (tc_inc >= len);
  assign bc_inc    = {1'b0, bc_eff} + {{BIT_CNT_W{1'b0}}, 1'b1};
  assign last_bit  = (bc_inc >= (BIT_CNT_W + 1)'(BITS_PER_READ));
  assign done      = (ph_eff == PH_LOW) && end_phase && last_bit;

  // next phase
  always_comb begin
    phase_nxt = ph_eff;
    if (end_phase) begin
      unique case (ph_eff)
        PH_IDLE:  phase_nxt = PH_IDLE;
        PH_LATCH: phase_nxt = PH_HIGH;
        PH_HIGH:  phase_nxt = PH_LOW;
        PH_LOW:   phase_nxt = last_bit ? PH_IDLE : PH_HIGH;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  npp_report u_report (
    .pad_byte    (shift_byte_nxt),
    .mode        (mode_r),
    .mic_pending (mic_p1),
    .rpt         (rpt)
  );

  // datapath and report decision
  always_comb begin
    mic_p1            = mic_pending_r | ~mic_r;
    mic_c1            = mic_changed_r | ~mic_r;
    tick_count_nxt    = tc_eff;
    bit_count_nxt     = bc_eff;
    shift_byte_nxt    = sb_eff;
    if (ph_eff == PH_LOW && tc_eff == 8'd0) begin
      shift_byte_nxt = {sb_eff[6:0], ~data_r};
    end
    if (ph_eff != PH_IDLE) begin
      tick_count_nxt = end_phase ? 8'd0 : tc_inc;
      if (ph_eff == PH_LOW && end_phase) bit_count_nxt = bc_inc[BIT_CNT_W-1:0];
    end
    report            = done && (mic_c1 || shift_byte_nxt != last_reported_r);
    last_reported_nxt = report ? shift_byte_nxt : last_reported_r;
    mic_pending_nxt   = report ? 1'b0 : mic_p1;
    mic_changed_nxt   = report ? rpt.mic_changed : mic_c1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      tick_count_r    <= 8'd0;
      bit_count_r     <= '0;
      shift_byte_r    <= 8'd0;
      last_reported_r <= 8'd0;
      mic_pending_r   <= 1'b0;
      mic_changed_r   <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      bit_count_r     <= bit_count_nxt;
      shift_byte_r    <= shift_byte_nxt;
      last_reported_r <= last_reported_nxt;
      mic_pending_r   <= mic_pending_nxt;
      mic_changed_r   <= mic_changed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_latch_out    <= (ph_eff == PH_LATCH);
      out_clock_out    <= (ph_eff != PH_LOW);
      out_busy_res     <= (ph_eff != PH_IDLE);
      out_report_valid <= report;
      out_axis_x       <= report ? rpt.axis_x : AXIS_CENTER;
      out_axis_y       <= report ? rpt.axis_y : AXIS_CENTER;
      out_buttons      <= report ? rpt.buttons : 4'd0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_latch_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_latch_out |-> out_clock_out)
    else $error("latch driven while clock low");

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_report_valid |-> out_busy_res)
    else $error("report outside a read");

  a_no_report_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_report_valid |->
      out_axis_x == AXIS_CENTER && out_axis_y == AXIS_CENTER && out_buttons == 4'd0)
    else $error("report fields set without a report");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_count_r == 8'd0)
    else $error("tick count left over in idle");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled with room downstream");
`endif

endmodule

FILE: rtl/npp_report.sv
module npp_report
  import npp_pkg::*;
(
  input  logic [7:0] pad_byte,
  input  mode_t      mode,
  input  logic       mic_pending,
  output report_t    rpt
);

  logic both;

  assign both = pad_byte[7] & pad_byte[6];

  always_comb begin
    rpt.axis_x = AXIS_CENTER;
    rpt.axis_y = AXIS_CENTER;
    if (pad_byte[0]) rpt.axis_x = AXIS_MAX;
    if (pad_byte[1]) rpt.axis_x = AXIS_MIN;
    if (pad_byte[2]) rpt.axis_y = AXIS_MAX;
    if (pad_byte[3]) rpt.axis_y = AXIS_MIN;
    rpt.buttons = 4'd0;
    rpt.mic_changed = mic_pending;
    unique case (mode)
      MODE_PLAIN: begin
        rpt.buttons = {pad_byte[4], pad_byte[5], pad_byte[6], pad_byte[7]};
        rpt.mic_changed = 1'b0;
      end
      MODE_FAMICOM: begin
        rpt.buttons = {mic_pending, both, pad_byte[6], pad_byte[7]};
      end
      MODE_A_HELD: begin
        // a+b together overrides the single-button bits
        rpt.buttons = both ? {2'b01, 1'b0, mic_pending}
                           : {pad_byte[7], 1'b0, pad_byte[6], mic_pending};
      end
      MODE_B_HELD: begin
        rpt.buttons = both ? {2'b01, mic_pending, 1'b0}
                           : {pad_byte[6], 1'b0, mic_pending, pad_byte[7]};
      end
      default: begin
        rpt.buttons = 4'd0;
      end
    endcase
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import npp_pkg::*;

  typedef struct packed {
    bit start;
    bit data;
    bit mic;
  } tick_req_t;

  typedef struct packed {
    bit       latch_lv;
    bit       clock_lv;
    bit       busy;
    bit       report;
    bit [7:0] ax;
    bit [7:0] ay;
    bit [3:0] btn;
  } pad_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_start_poll = 1'b0;
  logic                  in_data_level = 1'b1;
  logic                  in_mic_level = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_latch_out;
  logic                  out_clock_out;
  logic                  out_busy_res;
  logic                  out_report_valid;
  logic [7:0]            out_axis_x;
  logic [7:0]            out_axis_y;
  logic [3:0]            out_buttons;

  nes_pad_poller_hid_report_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_poll(in_start_poll),
    .in_data_level(in_data_level),
    .in_mic_level(in_mic_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_latch_out(out_latch_out),
    .out_clock_out(out_clock_out),
    .out_busy_res(out_busy_res),
    .out_report_valid(out_report_valid),
    .out_axis_x(out_axis_x),
    .out_axis_y(out_axis_y),
    .out_buttons(out_buttons)
  );

  tick_req_t   req_q[$];
  pad_result_t poll_result_q[$];
  tick_req_t   cur_req;
  int          err_cnt = 0;
  int          accepted_cnt = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  bit          steady = 1'b0;

  // predictor copy of registers and sequencer state
  mode_t    mode_r;
  bit [7:0] latch_len;
  bit [7:0] half_len;
  phase_t   seq_ph;
  bit [7:0] tick_cnt;
  bit [3:0] bit_cnt;
  bit [7:0] shift_reg;
  bit [7:0] last_byte;
  bit [7:0] shown_byte;
  bit       mic_pend;
  bit       mic_chg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [3:0] map_pad_buttons(bit [7:0] b);
    bit [3:0] r;
    bit       both;
    bit       m;
    r = '0;
    both = b[7] & b[6];
    m = mic_pend;
    case (mode_r)
      MODE_PLAIN: begin
        r = {b[4], b[5], b[6], b[7]};
        mic_pend = 1'b0;
        mic_chg = 1'b0;
        return r;
      end
      MODE_FAMICOM: begin
        r = {m, both, b[6], b[7]};
      end
      MODE_A_HELD: begin
        r[0] = m;
        if (both) r[2] = 1'b1;
        else begin
          r[1] = b[6];
          r[3] = b[7];
        end
      end
      default: begin
        r[1] = m;
        if (both) r[2] = 1'b1;
        else begin
          r[0] = b[7];
          r[3] = b[6];
        end
      end
    endcase
    mic_pend = 1'b0;
    mic_chg = m;
    return r;
  endfunction

  function automatic pad_result_t step_pad_seq(tick_req_t rq);
    pad_result_t r;
    bit          done;
    bit [7:0]    len;
    r = '0;
    r.ax = AXIS_CENTER;
    r.ay = AXIS_CENTER;
    done = 1'b0;
    if (!rq.mic) begin
      mic_pend = 1'b1;
      mic_chg = 1'b1;
    end
    if (seq_ph == PH_IDLE && rq.start) begin
      seq_ph = PH_LATCH;
      tick_cnt = '0;
      bit_cnt = '0;
      shift_reg = '0;
    end
    r.latch_lv = (seq_ph == PH_LATCH);
    r.clock_lv = (seq_ph != PH_LOW);
    r.busy = (seq_ph != PH_IDLE);
    if (seq_ph != PH_IDLE) begin
      if (seq_ph == PH_LOW && tick_cnt == 0) shift_reg = {shift_reg[6:0], ~rq.data};
      len = (seq_ph == PH_LATCH) ? latch_len : half_len;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= len) begin
        tick_cnt = '0;
        if (seq_ph == PH_LATCH) seq_ph = PH_HIGH;
        else if (seq_ph == PH_HIGH) seq_ph = PH_LOW;
        else begin
          if (int'(bit_cnt) + 1 >= BITS_PER_READ) begin
            done = 1'b1;
            seq_ph = PH_IDLE;
          end else seq_ph = PH_HIGH;
          bit_cnt = bit_cnt + 4'd1;
        end
      end
    end
    if (done) begin
      last_byte = shift_reg;
      if (mic_chg || last_byte != shown_byte) begin
        shown_byte = last_byte;
        r.report = 1'b1;
        if (last_byte[0]) r.ax = AXIS_MAX;
        if (last_byte[1]) r.ax = AXIS_MIN;
        if (last_byte[2]) r.ay = AXIS_MAX;
        if (last_byte[3]) r.ay = AXIS_MIN;
        r.btn = map_pad_buttons(last_byte);
      end
    end
    return r;
  endfunction

  task automatic check_field(string what, int got, int want);
    if (got != want) begin
      $display("mismatch %s: got %0h want %0h", what, got, want);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        poll_result_q.push_back(step_pad_seq(cur_req));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && (steady || hold_left != 0 || $urandom_range(99) >= 22)) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_start_poll <= cur_req.start;
          in_data_level <= cur_req.data;
          in_mic_level <= cur_req.mic;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!held_once && accepted_cnt >= 300) begin
      hold_left <= 150;
      held_once <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pad_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (poll_result_q.size() == 0) begin
          check_field("result with nothing expected", 1, 0);
        end else begin
          want = poll_result_q.pop_front();
          check_field("latch_out", (out_latch_out === 1'b1), want.latch_lv);
          check_field("clock_out", (out_clock_out === 1'b1), want.clock_lv);
          check_field("busy_res", (out_busy_res === 1'b1), want.busy);
          check_field("report_valid", (out_report_valid === 1'b1), want.report);
          check_field("axis_x", ($isunknown(out_axis_x) ? -1 : int'(out_axis_x)), want.ax);
          check_field("axis_y", ($isunknown(out_axis_y) ? -1 : int'(out_axis_y)), want.ay);
          check_field("buttons", ($isunknown(out_buttons) ? -1 : int'(out_buttons)), want.btn);
        end
      end
      out_stall <= (hold_left != 0) || (!steady && $urandom_range(99) < 22);
    end
  end

  task automatic push_req(bit start, bit data, bit mic);
    tick_req_t rq;
    rq.start = start;
    rq.data = data;
    rq.mic = mic;
    req_q.push_back(rq);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FAMICON_MODE: mode_r = mode_t'(val[1:0]);
      CFG_LATCH_TICKS: latch_len = val;
      CFG_HALF_BIT_TICKS: half_len = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(mode_t mode, logic [7:0] latch, logic [7:0] half);
    write_reg(CFG_FAMICON_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_LATCH_TICKS, latch);
    write_reg(CFG_HALF_BIT_TICKS, half);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || poll_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // pad data alternates between held levels, noise and slow drift
  task automatic queue_random(int n);
    int style;
    bit lvl;
    style = 0;
    lvl = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) style = $urandom_range(3);
      case (style)
        0: lvl = 1'b1;
        1: lvl = 1'b0;
        2: lvl = $urandom_range(1);
        default: if ($urandom_range(15) == 0) lvl = ~lvl;
      endcase
      push_req($urandom_range(3) != 0, lvl, $urandom_range(39) != 0);
    end
  endtask

  task automatic run_phase(mode_t mode, logic [7:0] latch, logic [7:0] half, int n,
                           bit quiet);
    wait_idle();
    set_regs(mode, latch, half);
    steady = quiet;
    queue_random(n);
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FAMICON_MODE;
    cfg_wdata = '0;
    mode_r = MODE_PLAIN;
    latch_len = LATCH_TICKS_RST;
    half_len = HALF_BIT_TICKS_RST;
    seq_ph = PH_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    shift_reg = '0;
    last_byte = '0;
    shown_byte = '0;
    mic_pend = 1'b0;
    mic_chg = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero latch count, mic press, all buttons down, starts while busy
    set_regs(MODE_FAMICOM, 8'd0, 8'd1);
    push_req(1'b1, 1'b0, 1'b0);
    repeat (16) push_req(1'b1, 1'b0, 1'b1);
    push_req(1'b0, 1'b1, 1'b1);
    push_req(1'b0, 1'b0, 1'b1);
    push_req(1'b1, 1'b1, 1'b0);
    wait_idle();

    run_phase(MODE_PLAIN, 8'd1, 8'd1, 200, 1'b0);
    run_phase(MODE_FAMICOM, 8'd3, 8'd2, 200, 1'b0);
    run_phase(MODE_A_HELD, 8'd1, 8'd0, 150, 1'b0);
    run_phase(MODE_B_HELD, 8'd2, 8'd1, 200, 1'b1);
    run_phase(MODE_B_HELD, 8'd255, 8'd1, 280, 1'b0);
    run_phase(MODE_A_HELD, 8'd1, 8'd255, 400, 1'b0);
    run_phase(MODE_FAMICOM, 8'd1, 8'd1, 150, 1'b0);

    wait_idle();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
